// ===== src/c2dvn_pkg.sv =====
`default_nettype none
package c2dvn_pkg;

  localparam int KMAX    = 5;
  localparam int WMAX    = 1024;
  localparam int HMAX    = 1024;

  localparam int PIX_W   = 16;
  localparam int COEF_W  = 8;
  localparam int PROD_W  = PIX_W + COEF_W;
  localparam int ACC_W   = 28;
  localparam int CSUM_W  = 13;
  localparam int NCOEF   = 25;
  localparam int COEF_BITS = NCOEF * COEF_W;

  localparam int DIM_W   = 11;
  localparam int KS_W    = 3;
  localparam int CFG_W   = 64;
  localparam int CIDX_W  = 3;

  localparam logic [CIDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CIDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CIDX_W-1:0] REG_KSIZE  = 3'd2;
  localparam logic [CIDX_W-1:0] REG_BANK0  = 3'd3;
  localparam logic [CIDX_W-1:0] REG_BANK1  = 3'd4;
  localparam logic [CIDX_W-1:0] REG_BANK2  = 3'd5;
  localparam logic [CIDX_W-1:0] REG_BANK3  = 3'd6;

  localparam int COL_W   = $clog2(WMAX);
  localparam int ROW_W   = $clog2(HMAX);
  localparam int SLOT_W  = $clog2(KMAX + 1);
  localparam int IDX_W   = $clog2(KMAX * KMAX + 1);

  typedef logic signed [PIX_W-1:0] pix_t;
  typedef pix_t [KMAX-1:0] column_t;

  typedef struct packed {
    logic                     shift;
    logic [SLOT_W-1:0]        slot;
    logic                     en;
    logic signed [COEF_W-1:0] coef;
  } cell_ctrl_t;

  // Coefficients past the last one in the banks read as zero.
  function automatic logic signed [COEF_W-1:0] coef_at(input logic [COEF_BITS-1:0] flat,
                                                       input logic [IDX_W-1:0] idx);
    logic signed [COEF_W-1:0] c;
    c = '0;
    if (int'(idx) < NCOEF) begin
      c = flat[int'(idx)*COEF_W +: COEF_W];
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== src/c2dvn_bank.sv =====
`default_nettype none
module c2dvn_bank (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [c2dvn_pkg::COL_W-1:0] addr,
  input  wire c2dvn_pkg::pix_t            wdata,
  output c2dvn_pkg::pix_t                 rdata
);
  import c2dvn_pkg::*;

  pix_t mem [WMAX];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== src/c2dvn_cell.sv =====
`default_nettype none
module c2dvn_cell (
  input  wire logic                   clk,
  input  wire c2dvn_pkg::cell_ctrl_t  ctrl,
  input  wire c2dvn_pkg::column_t     col_in,
  output c2dvn_pkg::column_t          col_out,
  output logic signed [c2dvn_pkg::PROD_W-1:0] prod
);
  import c2dvn_pkg::*;

  column_t col;

  // The column moves one place toward the older end on every pixel.
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      col <= col_in;
    end
    if (ctrl.en) begin
      prod <= PROD_W'($signed(col[ctrl.slot]) * $signed(ctrl.coef));
    end else begin
      prod <= '0;
    end
  end

  assign col_out = col;

endmodule
`default_nettype wire

// ===== src/c2dvn_div.sv =====
`default_nettype none
module c2dvn_div (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               start,
  input  wire logic signed [c2dvn_pkg::ACC_W-1:0]  dividend,
  input  wire logic signed [c2dvn_pkg::CSUM_W-1:0] divisor,
  output logic signed [c2dvn_pkg::ACC_W-1:0]       quotient,
  output logic                                    done
);
  import c2dvn_pkg::*;

  localparam int CNT_W = $clog2(ACC_W + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [ACC_W-1:0]   num;
  logic [ACC_W-1:0]   q;
  logic [CSUM_W-1:0]  rem;
  logic [CSUM_W-1:0]  den;
  logic               neg;
  logic [CSUM_W:0]    trial;
  logic               qbit;

  always_comb begin
    trial = {rem, num[ACC_W-1]};
    qbit  = (trial >= {1'b0, den});
  end

  // Restoring division on magnitudes, one quotient bit per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ACC_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend[ACC_W-1] ? ACC_W'(-dividend) : ACC_W'(dividend);
      den <= divisor[CSUM_W-1] ? CSUM_W'(-divisor) : CSUM_W'(divisor);
      neg <= dividend[ACC_W-1] ^ divisor[CSUM_W-1];
      rem <= '0;
      q   <= '0;
    end else if (busy) begin
      num <= {num[ACC_W-2:0], 1'b0};
      q   <= {q[ACC_W-2:0], qbit};
      if (qbit) begin
        rem <= CSUM_W'(trial - {1'b0, den});
      end else begin
        rem <= CSUM_W'(trial);
      end
    end
  end

  assign quotient = neg ? ACC_W'(-$signed(q)) : $signed(q);

endmodule
`default_nettype wire

// ===== src/conv2d_valid_normalized_top.sv =====
// Path from the transfer of a pixel that completes a window to its result:
//   window shift, cell-chain multiply-accumulate (S_MAC, S_ACC), divider start, divider, output.
//   With a zero coefficient sum the divider is skipped.
// A new pixel is taken only once the last one has passed through all its states, output stalls
//   included. A configuration write holds off pixels while the coefficients are re-summed.
// Reset (synchronous, active high) restores default registers and counters, not line memory.
`default_nettype none
module conv2d_valid_normalized_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [15:0] pixel
  input  wire logic [0:0]  s_tuser,   // [0] frame_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [47:0]      m_tdata,   // [27:0] result_value, [37:28] out_row, [47:38] out_col
  output logic [0:0]       m_tuser,   // [0] div_zero
  output logic             m_tlast,
  input  wire logic        cfg_we,
  input  wire logic [c2dvn_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [c2dvn_pkg::CFG_W-1:0]  cfg_data
);
  import c2dvn_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_MAC   = 3'd2;
  localparam logic [2:0] S_ACC   = 3'd3;
  localparam logic [2:0] S_START = 3'd4;
  localparam logic [2:0] S_DIVW  = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  localparam int COEF_SUM_RST = 1;

  // configuration
  logic [DIM_W-1:0]  image_width;
  logic [DIM_W-1:0]  image_height;
  logic [KS_W-1:0]   kernel_size;
  logic [CFG_W-1:0]  coef_bank0;
  logic [CFG_W-1:0]  coef_bank1;
  logic [CFG_W-1:0]  coef_bank2;
  logic [COEF_W-1:0] coef_bank3;
  logic [COEF_BITS-1:0] coef_flat;

  logic [DIM_W-1:0]  w_eff;
  logic [DIM_W-1:0]  h_eff;
  logic [KS_W-1:0]   k_eff;
  logic [DIM_W-1:0]  k_dim;
  logic [SLOT_W-1:0] off;
  logic [IDX_W-1:0]  kk;

  // coefficient sum sweep
  logic                     sum_busy;
  logic [IDX_W-1:0]         sum_idx;
  logic signed [CSUM_W-1:0] sum_acc;
  logic signed [CSUM_W-1:0] sum_term;
  logic signed [CSUM_W-1:0] coef_sum;

  // position
  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic [SLOT_W-1:0] bank_ptr;

  logic              accept;
  logic [COL_W-1:0]  cur_col;
  logic [ROW_W-1:0]  cur_row;
  logic [SLOT_W-1:0] cur_ptr;
  logic [DIM_W-1:0]  col_d;
  logic [DIM_W-1:0]  row_d;
  logic [DIM_W-1:0]  col_p1;
  logic [DIM_W-1:0]  row_p1;
  logic              cur_produce;
  logic              cur_last;

  // item held while it is worked on
  pix_t              item_pixel;
  logic [SLOT_W-1:0] item_ptr;
  logic              item_produce;
  logic              item_last;
  logic [ROW_W-1:0]  item_r0;
  logic [COL_W-1:0]  item_c0;
  logic              item_dz;

  logic [2:0]        state;
  logic [SLOT_W-1:0] step;
  logic              prod_vld;

  logic [KMAX-1:0]   bank_we;
  pix_t              rdata [KMAX];
  column_t           new_col;
  column_t           link [KMAX];
  cell_ctrl_t        ctrl [KMAX];
  logic signed [PROD_W-1:0] prod [KMAX];
  logic signed [ACC_W-1:0]  prod_sum;
  logic signed [ACC_W-1:0]  acc;

  logic                     div_start;
  logic                     div_done;
  logic signed [ACC_W-1:0]  div_q;
  logic                     out_load;

  assign coef_flat = {coef_bank3, coef_bank2, coef_bank1, coef_bank0};

  always_comb begin
    if (image_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (image_width > DIM_W'(WMAX)) begin
      w_eff = DIM_W'(WMAX);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (image_height > DIM_W'(HMAX)) begin
      h_eff = DIM_W'(HMAX);
    end else begin
      h_eff = image_height;
    end
    if (kernel_size == '0) begin
      k_eff = KS_W'(1);
    end else if (kernel_size > KS_W'(KMAX)) begin
      k_eff = KS_W'(KMAX);
    end else begin
      k_eff = kernel_size;
    end
    k_dim = DIM_W'(k_eff);
    off   = SLOT_W'(KMAX - int'(k_eff));
    kk    = IDX_W'(int'(k_eff) * int'(k_eff));
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= DIM_W'(1024);
      image_height <= DIM_W'(1024);
      kernel_size  <= KS_W'(3);
      coef_bank0   <= CFG_W'(1);
      coef_bank1   <= '0;
      coef_bank2   <= '0;
      coef_bank3   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[DIM_W-1:0];
        REG_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        REG_KSIZE:  kernel_size  <= cfg_data[KS_W-1:0];
        REG_BANK0:  coef_bank0   <= cfg_data;
        REG_BANK1:  coef_bank1   <= cfg_data;
        REG_BANK2:  coef_bank2   <= cfg_data;
        REG_BANK3:  coef_bank3   <= cfg_data[COEF_W-1:0];
        default: ;
      endcase
    end
  end

  // Any register write re-sums the active coefficients, one per cycle.
  always_comb begin
    sum_term = '0;
    if (sum_idx < kk) begin
      sum_term = CSUM_W'(coef_at(coef_flat, sum_idx));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_busy <= 1'b0;
      sum_idx  <= '0;
      sum_acc  <= '0;
      coef_sum <= CSUM_W'(COEF_SUM_RST);
    end else if (cfg_we && cfg_index <= REG_BANK3) begin
      sum_busy <= 1'b1;
      sum_idx  <= '0;
      sum_acc  <= '0;
    end else if (sum_busy) begin
      sum_acc <= sum_acc + sum_term;
      sum_idx <= sum_idx + 1'b1;
      if (sum_idx == IDX_W'(KMAX * KMAX - 1)) begin
        coef_sum <= sum_acc + sum_term;
        sum_busy <= 1'b0;
      end
    end
  end

  assign s_tready = (state == S_IDLE) && !sum_busy;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    cur_col = s_tuser[0] ? '0 : column_count;
    cur_row = s_tuser[0] ? '0 : row_count;
    cur_ptr = s_tuser[0] ? '0 : bank_ptr;
    col_d   = DIM_W'(cur_col);
    row_d   = DIM_W'(cur_row);
    col_p1  = col_d + 1'b1;
    row_p1  = row_d + 1'b1;
    cur_produce = (w_eff >= k_dim) && (h_eff >= k_dim) &&
                  (row_d >= k_dim - 1'b1) && (col_d >= k_dim - 1'b1) &&
                  (row_d < h_eff) && (col_d < w_eff);
    cur_last = (row_d == h_eff - 1'b1) && (col_d == w_eff - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      bank_ptr     <= '0;
      item_produce <= 1'b0;
    end else if (accept) begin
      item_produce <= cur_produce;
      if (col_p1 >= w_eff) begin
        column_count <= '0;
        if (row_p1 >= h_eff) begin
          row_count <= '0;
          bank_ptr  <= '0;
        end else begin
          row_count <= ROW_W'(row_p1);
          bank_ptr  <= (cur_ptr == SLOT_W'(KMAX - 1)) ? '0 : cur_ptr + 1'b1;
        end
      end else begin
        column_count <= COL_W'(col_p1);
        row_count    <= cur_row;
        bank_ptr     <= cur_ptr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_pixel <= $signed(s_tdata);
      item_ptr   <= cur_ptr;
      item_last  <= cur_last;
      item_r0    <= ROW_W'(row_d - (k_dim - 1'b1));
      item_c0    <= COL_W'(col_d - (k_dim - 1'b1));
    end
  end

  // One memory bank per kernel row; the current row goes to the bank of the row count.
  genvar gb;
  generate
    for (gb = 0; gb < KMAX; gb++) begin : g_bank
      assign bank_we[gb] = accept && (cur_ptr == SLOT_W'(gb));
      c2dvn_bank u_bank (
        .clk   (clk),
        .we    (bank_we[gb]),
        .addr  (cur_col),
        .wdata ($signed(s_tdata)),
        .rdata (rdata[gb])
      );
    end
  endgenerate

  // New window column, oldest row first; the newest row is the pixel itself.
  always_comb begin
    int sel;
    for (int a = 0; a < KMAX - 1; a++) begin
      sel = int'(item_ptr) + 1 + a;
      if (sel >= KMAX) begin
        sel = sel - KMAX;
      end
      new_col[a] = rdata[SLOT_W'(sel)];
    end
    new_col[KMAX-1] = item_pixel;
  end

  always_comb begin
    for (int j = 0; j < KMAX; j++) begin
      ctrl[j].shift = (state == S_SHIFT);
      ctrl[j].slot  = step;
      ctrl[j].en    = (state == S_MAC) && (step >= off) && (SLOT_W'(j) >= off);
      ctrl[j].coef  = coef_at(coef_flat,
                              IDX_W'((int'(step) - int'(off)) * int'(k_eff) + (j - int'(off))));
    end
  end

  genvar gc;
  generate
    for (gc = 0; gc < KMAX; gc++) begin : g_cell
      if (gc == KMAX - 1) begin : g_head
        c2dvn_cell u_cell (
          .clk     (clk),
          .ctrl    (ctrl[gc]),
          .col_in  (new_col),
          .col_out (link[gc]),
          .prod    (prod[gc])
        );
      end else begin : g_body
        c2dvn_cell u_cell (
          .clk     (clk),
          .ctrl    (ctrl[gc]),
          .col_in  (link[gc+1]),
          .col_out (link[gc]),
          .prod    (prod[gc])
        );
      end
    end
  endgenerate

  always_comb begin
    prod_sum = '0;
    for (int j = 0; j < KMAX; j++) begin
      prod_sum = prod_sum + ACC_W'(prod[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_SHIFT) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + prod_sum;
    end
  end

  assign div_start = (state == S_START) && (coef_sum != '0);
  assign out_load  = (state == S_OUT) && (!m_tvalid || m_tready);

  c2dvn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (acc),
    .divisor  (coef_sum),
    .quotient (div_q),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= '0;
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= (state == S_MAC);
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          step  <= '0;
          state <= item_produce ? S_MAC : S_IDLE;
        end
        S_MAC: begin
          step <= step + 1'b1;
          if (step == SLOT_W'(KMAX - 1)) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          state <= S_START;
        end
        S_START: begin
          state <= (coef_sum == '0) ? S_OUT : S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_START) begin
      item_dz <= (coef_sum == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata[ACC_W-1:0]   <= item_dz ? '0 : div_q;
      m_tdata[37:28]       <= item_r0;
      m_tdata[47:38]       <= item_c0;
      m_tuser[0]           <= item_dz;
      m_tlast              <= item_last;
    end
  end

  a_accept_shift: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_SHIFT)
    else $error("accepted pixel did not enter the window shift");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_start |-> coef_sum != '0)
    else $error("divider started with a zero coefficient sum");

  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIVW)
    else $error("divider finished outside the wait state");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> m_tvalid && state == S_IDLE)
    else $error("result load did not raise the output valid");

endmodule
`default_nettype wire
